// ----- hdl/user_activity_idle_detector_defines.svh -----
// Assertion macros for the checker file of the idle detector.
`ifndef USER_ACTIVITY_IDLE_DETECTOR_DEFINES_SVH
`define USER_ACTIVITY_IDLE_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define UAID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define UAID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/uaid_pkg.sv -----
// Shared types, codes and constants of the user activity idle detector.
package uaid_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_USING  = 2'd1,
    MODE_TRYING = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_POLL        = 3'd0,
    KIND_FORCE_IDLE  = 3'd1,
    KIND_FORCE_USING = 3'd2,
    KIND_TRACK_ON    = 3'd3,
    KIND_TRACK_OFF   = 3'd4
  } kind_t;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_IDLE   = 2'd1;
  localparam logic [1:0] EV_RETURN = 2'd2;

  localparam logic [1:0] REG_START_THR = 2'd0;
  localparam logic [1:0] REG_START_GAP = 2'd1;
  localparam logic [1:0] REG_STOP_THR  = 2'd2;

  localparam int unsigned TICK_W = 32;
  localparam int unsigned POLL_W = 31;

  localparam logic [TICK_W-1:0] START_THR_RESET = 32'd1000;
  localparam logic [TICK_W-1:0] START_GAP_RESET = 32'd200;
  localparam logic [TICK_W-1:0] STOP_THR_RESET  = 32'd1000;
  localparam logic [POLL_W-1:0] MIN_POLL_MS     = 31'd100;

  // floor(x/3) == (x * RECIP3) >> 33 for every 32-bit x
  localparam logic [TICK_W-1:0] RECIP3      = 32'hAAAA_AAAB;
  localparam int unsigned       RECIP3_SHIFT = 33;

  localparam logic [POLL_W-1:0] START_IV_RESET =
    (START_THR_RESET / 3 > MIN_POLL_MS) ? POLL_W'(START_THR_RESET / 3) : MIN_POLL_MS;
  localparam logic [POLL_W-1:0] GAP_IV_RESET =
    (START_GAP_RESET / 3 > MIN_POLL_MS) ? POLL_W'(START_GAP_RESET / 3) : MIN_POLL_MS;
  localparam logic [POLL_W-1:0] STOP_IV_RESET =
    (STOP_THR_RESET / 3 > MIN_POLL_MS) ? POLL_W'(STOP_THR_RESET / 3) : MIN_POLL_MS;

  typedef struct packed {
    logic [2:0]        kind;
    logic [TICK_W-1:0] now_ms;
    logic [TICK_W-1:0] last_input_ms;
  } req_item_t;

  typedef struct packed {
    logic [1:0]        event_res;
    logic [TICK_W-1:0] event_age_ms;
    logic [1:0]        mode;
    logic [POLL_W-1:0] next_poll_ms;
  } rsp_item_t;

  // Thresholds and their derived poll intervals, from the config block to the core.
  typedef struct packed {
    logic [TICK_W-1:0] start_thr;
    logic [TICK_W-1:0] start_gap;
    logic [TICK_W-1:0] stop_thr;
    logic [POLL_W-1:0] start_iv;
    logic [POLL_W-1:0] gap_iv;
    logic [POLL_W-1:0] stop_iv;
  } cfg_t;

endpackage

// ----- hdl/user_activity_idle_detector.sv -----
// Top level of the user activity idle detector.
// Tracks a user through idle, trying-to-use and in-use modes from polled
// millisecond ticks. One item is accepted per clock while req_stall is low;
// its result is registered in the output register, or the skid register if
// the output stalls. A two-entry result buffer parts input from output, so
// req_stall rises only when both entries hold untaken results. Each item
// passes through one compare-and-select stage on the state registers.
// Configuration writes are always ready; each write derives its poll
// interval (threshold/3, at least 100) through one multiply on the way in.
// Register indexes: 0 start threshold, 1 start gap, 2 stop threshold;
// index 3 is ignored.
module user_activity_idle_detector
  import uaid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_item_t         req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_item_t         rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [TICK_W-1:0] cfg_data
);

  cfg_t      cfg;
  rsp_item_t res;
  logic      fire;
  logic      full;

  assign cfg_ready = 1'b1;
  assign req_stall = full;
  assign fire      = req_valid && !full;

  uaid_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  uaid_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req),
    .cfg  (cfg),
    .res  (res)
  );

  uaid_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res       (res),
    .full      (full),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- hdl/uaid_cfg.sv -----
// Configuration registers and the poll interval derived from each threshold.
module uaid_cfg
  import uaid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [1:0]        index,
  input  logic [TICK_W-1:0] data,
  output cfg_t              cfg
);

  logic [2*TICK_W-1:0] prod;
  logic [POLL_W-1:0]   third;
  logic [POLL_W-1:0]   iv;

  // Divide by three through the reciprocal, then clamp to the minimum interval.
  assign prod  = data * RECIP3;
  assign third = prod[RECIP3_SHIFT +: POLL_W];
  assign iv    = (third > MIN_POLL_MS) ? third : MIN_POLL_MS;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_thr <= START_THR_RESET;
      cfg.start_gap <= START_GAP_RESET;
      cfg.stop_thr  <= STOP_THR_RESET;
      cfg.start_iv  <= START_IV_RESET;
      cfg.gap_iv    <= GAP_IV_RESET;
      cfg.stop_iv   <= STOP_IV_RESET;
    end else if (we) begin
      case (index)
        REG_START_THR: begin
          cfg.start_thr <= data;
          cfg.start_iv  <= iv;
        end
        REG_START_GAP: begin
          cfg.start_gap <= data;
          cfg.gap_iv    <= iv;
        end
        REG_STOP_THR: begin
          cfg.stop_thr <= data;
          cfg.stop_iv  <= iv;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/uaid_core.sv -----
// Activity mode state machine: state registers and the result of each item.
module uaid_core
  import uaid_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  req_item_t req,
  input  cfg_t      cfg,
  output rsp_item_t res
);

  mode_t             mode;
  mode_t             mode_next;
  logic [TICK_W-1:0] ref_tick;
  logic [TICK_W-1:0] ref_tick_next;
  logic              tracking;
  logic              tracking_next;

  logic [TICK_W-1:0] inp;
  logic [TICK_W-1:0] gap_age;
  logic [TICK_W-1:0] ref_age;
  logic              gap_over;
  logic              start_over;
  logic              stop_over;
  logic              is_poll;

  assign inp        = (req.last_input_ms > ref_tick) ? req.last_input_ms : ref_tick;
  assign gap_age    = req.now_ms - inp;
  assign ref_age    = req.now_ms - ref_tick;
  assign gap_over   = gap_age > cfg.start_gap;
  assign start_over = ref_age > cfg.start_thr;
  assign stop_over  = gap_age > cfg.stop_thr;
  assign is_poll    = (req.kind == KIND_POLL) && tracking;

  always_comb begin
    mode_next     = mode;
    ref_tick_next = ref_tick;
    tracking_next = tracking;
    case (req.kind)
      KIND_POLL: begin
        if (tracking) begin
          case (mode)
            MODE_TRYING: begin
              if (gap_over) begin
                mode_next     = MODE_IDLE;
                ref_tick_next = req.now_ms;
              end else if (start_over) begin
                mode_next     = MODE_USING;
                ref_tick_next = req.now_ms;
              end
            end
            MODE_USING: begin
              if (stop_over) begin
                mode_next     = MODE_IDLE;
                ref_tick_next = req.now_ms;
              end
            end
            default: begin
              mode_next = MODE_IDLE;
              if (inp > ref_tick) begin
                mode_next     = MODE_TRYING;
                ref_tick_next = inp;
              end
            end
          endcase
        end
      end
      KIND_FORCE_IDLE: begin
        mode_next     = MODE_IDLE;
        ref_tick_next = req.now_ms;
      end
      KIND_FORCE_USING: begin
        mode_next     = MODE_USING;
        ref_tick_next = req.now_ms;
      end
      KIND_TRACK_ON: begin
        ref_tick_next = req.now_ms;
        tracking_next = 1'b1;
      end
      KIND_TRACK_OFF: begin
        tracking_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.event_res    = EV_NONE;
    res.event_age_ms = '0;
    res.mode         = mode_next;
    case (mode_next)
      MODE_TRYING: res.next_poll_ms = cfg.gap_iv;
      MODE_USING:  res.next_poll_ms = cfg.stop_iv;
      default:     res.next_poll_ms = cfg.start_iv;
    endcase
    if (is_poll) begin
      case (mode)
        MODE_TRYING: begin
          if (!gap_over && start_over) begin
            res.event_res    = EV_RETURN;
            res.event_age_ms = ref_age;
          end
        end
        MODE_USING: begin
          if (stop_over) begin
            res.event_res    = EV_IDLE;
            res.event_age_ms = gap_age;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      ref_tick <= '0;
      tracking <= 1'b0;
    end else if (fire) begin
      mode     <= mode_next;
      ref_tick <= ref_tick_next;
      tracking <= tracking_next;
    end
  end

endmodule

// ----- hdl/uaid_obuf.sv -----
// Two-entry result buffer: output register plus skid register.
module uaid_obuf
  import uaid_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  rsp_item_t res,
  output logic      full,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  logic      skid_valid;
  rsp_item_t skid;
  logic      out_fire;

  assign out_fire = rsp_valid && !rsp_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // advance the parked item once the output drains
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (fire) begin
      if (!rsp_valid || out_fire) begin
        rsp_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        rsp <= skid;
      end
    end else if (fire) begin
      if (!rsp_valid || out_fire) begin
        rsp <= res;
      end else begin
        skid <= res;
      end
    end
  end

endmodule

// ----- hdl/uaid_checker.sv -----
// Port-level checker for the idle detector, bound to the top level.
`include "user_activity_idle_detector_defines.svh"

module uaid_checker
  import uaid_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_item_t rsp
);

  `UAID_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
  `UAID_ASSERT_NOW(a_poll_min, rsp_valid, rsp.next_poll_ms >= MIN_POLL_MS, "poll interval below minimum")
  `UAID_ASSERT_NOW(a_no_event_age, rsp_valid && rsp.event_res == EV_NONE, rsp.event_age_ms == '0, "age without event")
  `UAID_ASSERT_NOW(a_return_mode, rsp_valid && rsp.event_res == EV_RETURN, rsp.mode == MODE_USING, "return event outside using mode")
  `UAID_ASSERT_NOW(a_idle_mode, rsp_valid && rsp.event_res == EV_IDLE, rsp.mode == MODE_IDLE, "idle event outside idle mode")

endmodule

bind user_activity_idle_detector uaid_checker u_chk (.*);
